[sv/assert_macros.svh]
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[sv/ity_pkg.sv]
// Types, character codes and precedence tables for the infix to postfix converter.
`timescale 1ns / 1ps

package ity_pkg;

  localparam int unsigned StackDepthDef = 32;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef logic signed [4:0] prec_t;

  localparam prec_t PrecBottom = -5'sd1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } ity_in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last;
    logic       overflow;
  } ity_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ity_shift_t;

  function automatic prec_t stack_prec(logic [7:0] c);
    prec_t p;
    case (c)
      ChPlus, ChMinus:  p = 5'sd2;
      ChStar, ChSlash:  p = 5'sd4;
      ChCaret, ChDollar: p = 5'sd5;
      ChOpen:           p = 5'sd0;
      ChHash:           p = -5'sd1;
      default:          p = 5'sd8;
    endcase
    return p;
  endfunction

  function automatic prec_t input_prec(logic [7:0] c);
    prec_t p;
    case (c)
      ChPlus, ChMinus:  p = 5'sd1;
      ChStar, ChSlash:  p = 5'sd3;
      ChCaret, ChDollar: p = 5'sd6;
      ChOpen:           p = 5'sd9;
      ChClose:          p = 5'sd0;
      default:          p = 5'sd7;
    endcase
    return p;
  endfunction

endpackage

[sv/ity_cell.sv]
// One entry of the shifting operator stack.
`timescale 1ns / 1ps

module ity_cell (
  input  logic               clk_i,
  input  ity_pkg::ity_shift_t shift_i,
  input  logic [7:0]         prev_i,
  input  logic [7:0]         next_i,
  output logic [7:0]         data_o
);
  import ity_pkg::*;

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i.push) begin
      data_d = prev_i;
    end else if (shift_i.pop) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[sv/ity_stack.sv]
// Row of stack cells; the top of stack sits in the first cell.
`timescale 1ns / 1ps

module ity_stack #(
  parameter int unsigned STACK_DEPTH = ity_pkg::StackDepthDef
) (
  input  logic                clk_i,
  input  ity_pkg::ity_shift_t shift_i,
  input  logic [7:0]          push_data_i,
  output logic [7:0]          top_o
);
  import ity_pkg::*;

  logic [7:0] cell_data [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] prev_data;
    logic [7:0] next_data;

    if (i == 0) begin : g_head
      assign prev_data = push_data_i;
    end else begin : g_body
      assign prev_data = cell_data[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign next_data = ChNul;
    end else begin : g_link
      assign next_data = cell_data[i+1];
    end

    ity_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

[sv/infix_to_postfix_converter.sv]
// Top level of the infix to postfix converter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Shunting-yard converter: infix characters in, postfix characters out, one item at a
// time. The operator stack is a row of STACK_DEPTH shifting cells with the top in the
// first cell, so a push or pop moves every entry one place at once. For a symbol item,
// S_SCAN sends out each operator that outranks it, then pushes it or pops its match; an
// end-of-expression item makes S_FLUSH send out every stack entry and then the NUL
// terminator with last set. Each character sent out needs a free output register, so a
// stalled output holds up the conversion. overflow reports a push dropped on a full stack
// since the last terminator and is cleared once the terminator is issued.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = ity_pkg::StackDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ity_pkg::ity_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ity_pkg::ity_out_t out_req_o
);
  import ity_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;
  ity_out_t    out_q, out_d;
  logic [7:0]  sym_q, sym_d;

  ity_shift_t  shift;
  logic [7:0]  top;
  prec_t       top_prec;
  prec_t       in_prec;
  logic        out_free;
  logic        full;
  logic        empty;

  ity_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .shift_i     (shift),
    .push_data_i (sym_q),
    .top_o       (top)
  );

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CntW'(STACK_DEPTH));
  assign top_prec = empty ? PrecBottom : stack_prec(top);
  assign in_prec  = input_prec(sym_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    sym_d       = sym_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    shift       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d   = in_req_i.symbol;
          state_d = in_req_i.end_of_expression ? S_FLUSH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (top_prec > in_prec) begin
          if (out_free) begin
            shift.pop   = 1'b1;
            cnt_d       = cnt_q - CntW'(1);
            out_valid_d = 1'b1;
            out_d       = '{out_symbol: top, last: 1'b0, overflow: ovf_q};
          end
        end else if (top_prec != in_prec) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            shift.push = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
          end
          state_d = S_IDLE;
        end else begin
          shift.pop = 1'b1;
          cnt_d     = cnt_q - CntW'(1);
          state_d   = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!empty) begin
            shift.pop = 1'b1;
            cnt_d     = cnt_q - CntW'(1);
            out_d     = '{out_symbol: top, last: 1'b0, overflow: ovf_q};
          end else begin
            out_d   = '{out_symbol: ChNul, last: 1'b1, overflow: ovf_q};
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(STACK_DEPTH), "stack count past depth")
  `ASSERT_PROP(a_ovf_full, clk_i, rst_ni, $rose(ovf_q) |-> $past(full), "overflow without full stack")
  `ASSERT_PROP(a_term_clear, clk_i, rst_ni, (state_q == S_FLUSH && empty && out_free) |=> (cnt_q == '0 && !ovf_q && out_valid_q && out_q.last), "terminator left state behind")
  `ASSERT_PROP(a_shift_excl, clk_i, rst_ni, shift.push |-> !shift.pop && !full, "push collides with pop or full stack")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the infix to postfix converter.
`timescale 1ns / 1ps

module testbench;
  import ity_pkg::*;

  localparam int unsigned Depth = StackDepthDef;
  localparam int IdleLimit = 3000;
  localparam int LongHold = 300;
  localparam int TargetItems = 425;

  class postfix_scoreboard;
    logic [7:0] op_stack[Depth];
    int unsigned fill = 0;
    bit dropped_push = 1'b0;
    ity_out_t expected_q[$];
    int errors = 0;

    static function int rank_on_stack(logic [7:0] c);
      case (c)
        ChPlus, ChMinus: return 2;
        ChStar, ChSlash: return 4;
        ChCaret, ChDollar: return 5;
        ChOpen: return 0;
        ChHash: return -1;
        default: return 8;
      endcase
    endfunction

    static function int rank_incoming(logic [7:0] c);
      case (c)
        ChPlus, ChMinus: return 1;
        ChStar, ChSlash: return 3;
        ChCaret, ChDollar: return 6;
        ChOpen: return 9;
        ChClose: return 0;
        default: return 7;
      endcase
    endfunction

    function int top_rank();
      if (fill == 0) return -1;
      return rank_on_stack(op_stack[fill-1]);
    endfunction

    function void expect_char(logic [7:0] c, logic is_last);
      ity_out_t res;
      res.out_symbol = c;
      res.last = is_last;
      res.overflow = dropped_push;
      expected_q.push_back(res);
    endfunction

    function void note_request(ity_in_t req);
      int incoming;
      logic [7:0] popped[$];
      if (req.end_of_expression) begin
        while (fill > 0) begin
          fill--;
          expect_char(op_stack[fill], 1'b0);
        end
        expect_char(ChNul, 1'b1);
        dropped_push = 1'b0;
        return;
      end
      incoming = rank_incoming(req.symbol);
      while (top_rank() > incoming) begin
        fill--;
        popped.push_back(op_stack[fill]);
      end
      if (top_rank() != incoming) begin
        if (fill < Depth) begin
          op_stack[fill] = req.symbol;
          fill++;
        end else begin
          dropped_push = 1'b1;
        end
      end else if (fill > 0) begin
        fill--;
      end
      foreach (popped[i]) expect_char(popped[i], 1'b0);
    endfunction

    function void check_result(ity_out_t got);
      ity_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_symbol %0h last %0b overflow %0b",
               got.out_symbol, got.last, got.overflow);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_symbol !== want.out_symbol) begin
        $error("out_symbol: expected %0h, got %0h", want.out_symbol, got.out_symbol);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ity_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ity_out_t out_req_o;

  postfix_scoreboard sb = new();
  ity_in_t stim_q[$];
  int sent = 0;
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  int idle_cycles = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_sym(logic [7:0] c);
    ity_in_t req;
    req.symbol = c;
    req.end_of_expression = 1'b0;
    stim_q.push_back(req);
  endfunction

  function automatic void add_end();
    ity_in_t req;
    req.symbol = 8'($urandom_range(0, 255));
    req.end_of_expression = 1'b1;
    stim_q.push_back(req);
  endfunction

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return ChHash;
      1: return ChNul;
      2: return 8'($urandom_range(48, 57));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] ops[6];
    ops = '{ChPlus, ChMinus, ChStar, ChSlash, ChCaret, ChDollar};
    return ops[$urandom_range(0, 5)];
  endfunction

  function automatic void build_well_formed();
    int opened = 0;
    int terms;
    terms = $urandom_range(1, 8);
    for (int t = 0; t < terms; t++) begin
      while ($urandom_range(0, 3) == 0 && opened < 6) begin
        add_sym(ChOpen);
        opened++;
      end
      add_sym(pick_operand());
      while (opened > 0 && $urandom_range(0, 2) == 0) begin
        add_sym(ChClose);
        opened--;
      end
      if (t != terms - 1) add_sym(pick_operator());
    end
    repeat (opened) add_sym(ChClose);
    add_end();
  endfunction

  function automatic void build_deep(int opens);
    repeat (opens) add_sym(ChOpen);
    add_sym(pick_operand());
    repeat ($urandom_range(0, 3)) add_sym(ChClose);
    add_end();
  endfunction

  task automatic send_request(ity_in_t req);
    int gap;
    gap = tx_busy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk); while (!in_ready_o);
    sb.note_request(req);
    sent++;
    if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
  endtask

  task automatic send_queued();
    while (stim_q.size() > 0) send_request(stim_q.pop_front());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // receiver: random backpressure, one long hold-off
  initial begin
    int stall;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_ni) @(posedge clk);
    forever begin
      if (!held && taken == 60) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk);
        held = 1'b1;
      end else begin
        stall = rx_busy ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
      taken++;
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_req_o);
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL infix_to_postfix_converter");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    int idx;
    bit paused;
    ity_in_t stray;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    add_sym("a"); add_sym(ChPlus); add_sym("b"); add_sym(ChStar); add_sym("c");
    add_end();
    add_sym(ChOpen); add_sym("x"); add_sym(ChMinus); add_sym("y"); add_sym(ChClose);
    add_sym(ChSlash); add_sym("z"); add_sym(ChCaret); add_sym("w"); add_sym(ChDollar);
    add_sym("v"); add_end();
    add_sym(ChClose); add_sym(ChNul); add_sym(8'hFF); add_sym(ChHash); add_sym(ChPlus);
    add_end();
    send_queued();
    drain();

    build_deep(Depth + 2);
    send_queued();

    while (sent < TargetItems) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        build_well_formed();
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 8)) add_sym(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) add_end();
      end else if (kind < 18) begin
        build_well_formed();
        repeat ($urandom_range(1, 2)) begin
          stray.symbol = $urandom_range(0, 1) ? ChOpen : ChClose;
          stray.end_of_expression = 1'b0;
          idx = $urandom_range(0, stim_q.size() - 1);
          stim_q.insert(idx, stray);
        end
      end else begin
        build_deep($urandom_range(Depth - 4, Depth + 4));
      end
      send_queued();
      if (!paused && sent >= 200) begin
        drain();
        paused = 1'b1;
      end
    end

    add_end();
    send_queued();
    drain();
    repeat (Depth + 20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS infix_to_postfix_converter");
    end else begin
      $display("FAIL infix_to_postfix_converter");
    end
    $finish;
  end

endmodule
